// ===== rtl/ctsc_pkg.sv =====
// Package for the clock time-set controller: tick width, action codes,
// register indexes and the structs passed between the modules.
// No dependencies.
`default_nettype none

package ctsc_pkg;

    localparam int TICK_WIDTH = 32;
    localparam int CFG_WIDTH  = 32;
    localparam int CMP_WIDTH  = (TICK_WIDTH > CFG_WIDTH) ? TICK_WIDTH : CFG_WIDTH;

    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;

    localparam logic [HOUR_W-1:0] HOUR_MAX = HOUR_W'(23);
    localparam logic [MIN_W-1:0]  MIN_MAX  = MIN_W'(59);

    localparam logic [2:0] BTN_NONE = 3'b000;
    localparam logic [2:0] BTN_MENU = 3'b100;
    localparam int BTN_DOWN_BIT = 0;
    localparam int BTN_UP_BIT   = 1;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic POS_HOURS   = 1'b0;
    localparam logic POS_MINUTES = 1'b1;

    typedef logic [TICK_WIDTH-1:0] tick_t;
    typedef logic [CFG_WIDTH-1:0]  cfg_word_t;

    typedef enum logic [0:0] {
        CFG_CLICK_DELAY = 1'b0,
        CFG_LONG_PRESS  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_INC_HOUR = 3'd1,
        ACT_DEC_HOUR = 3'd2,
        ACT_INC_MIN  = 3'd3,
        ACT_DEC_MIN  = 3'd4,
        ACT_TOGGLE   = 3'd5,
        ACT_DONE     = 3'd6
    } action_t;

    typedef struct packed {
        cfg_word_t click_delay;
        cfg_word_t long_press_limit;
    } cfg_t;

    typedef struct packed {
        logic              command;
        logic [2:0]        buttons;
        tick_t             now_ticks;
        logic [HOUR_W-1:0] load_hours;
        logic [MIN_W-1:0]  load_minutes;
    } item_t;

    typedef struct packed {
        action_t           action;
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic              field_selected;
    } result_t;

    // True when (now - start) mod 2^TICK_WIDTH is below limit.
    function automatic logic elapsed_below(tick_t now, tick_t start, cfg_word_t limit);
        tick_t diff;
        diff = now - start;
        return CMP_WIDTH'(diff) < CMP_WIDTH'(limit);
    endfunction

    // True when (now - start) mod 2^TICK_WIDTH is above limit.
    function automatic logic elapsed_above(tick_t now, tick_t start, cfg_word_t limit);
        tick_t diff;
        diff = now - start;
        return CMP_WIDTH'(diff) > CMP_WIDTH'(limit);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ctsc_cfg.sv =====
// Configuration registers of the clock time-set controller.
// Depends on ctsc_pkg.
`default_nettype none

module ctsc_cfg
    import ctsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire logic      wr_index,
    input  wire cfg_word_t wr_data,
    output cfg_t           cfg
);

    cfg_word_t click_delay_reg;
    cfg_word_t long_press_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_delay_reg <= CFG_WIDTH'(200);
            long_press_reg  <= CFG_WIDTH'(2000);
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_CLICK_DELAY: click_delay_reg <= wr_data;
                CFG_LONG_PRESS:  long_press_reg  <= wr_data;
                default:         ;
            endcase
        end
    end

    assign cfg.click_delay      = click_delay_reg;
    assign cfg.long_press_limit = long_press_reg;

endmodule

`default_nettype wire

// ===== rtl/ctsc_step.sv =====
// Per-item update of the controller state: button timing, field select
// and hour/minute counters. Depends on ctsc_pkg.
`default_nettype none

module ctsc_step
    import ctsc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    logic [2:0]        last_pattern_reg, last_pattern_next;
    tick_t             hold_start_reg,   hold_start_next;
    tick_t             click_start_reg,  click_start_next;
    logic              click_armed_reg,  click_armed_next;
    logic              position_reg,     position_next;
    logic [HOUR_W-1:0] hour_reg,         hour_next;
    logic [MIN_W-1:0]  minute_reg,       minute_next;
    action_t           action;
    tick_t             click_ref;

    always_comb
    begin
        last_pattern_next = last_pattern_reg;
        hold_start_next   = hold_start_reg;
        click_start_next  = click_start_reg;
        click_armed_next  = click_armed_reg;
        position_next     = position_reg;
        hour_next         = hour_reg;
        minute_next       = minute_reg;
        action            = ACT_NONE;
        click_ref         = click_armed_reg ? click_start_reg : item.now_ticks;

        if (item.command == CMD_LOAD)
        begin
            hour_next   = (item.load_hours > HOUR_MAX) ? HOUR_MAX : item.load_hours;
            minute_next = (item.load_minutes > MIN_MAX) ? MIN_MAX : item.load_minutes;
        end
        else if (item.buttons == BTN_NONE)
        begin
            // release: drop the press history, keep the click timer
            hold_start_next   = '0;
            last_pattern_next = BTN_NONE;
        end
        else
        begin
            click_start_next = click_ref;
            click_armed_next = 1'b1;
            if (!elapsed_below(item.now_ticks, click_ref, cfg.click_delay))
            begin
                click_armed_next = 1'b0;
                if (item.buttons[BTN_DOWN_BIT])
                begin
                    if (position_reg == POS_HOURS)
                    begin
                        hour_next = (hour_reg == '0) ? HOUR_MAX : hour_reg - 1'b1;
                        action    = ACT_DEC_HOUR;
                    end
                    else
                    begin
                        minute_next = (minute_reg == '0) ? MIN_MAX : minute_reg - 1'b1;
                        action      = ACT_DEC_MIN;
                    end
                end
                else if (item.buttons[BTN_UP_BIT])
                begin
                    if (position_reg == POS_HOURS)
                    begin
                        hour_next = (hour_reg >= HOUR_MAX) ? '0 : hour_reg + 1'b1;
                        action    = ACT_INC_HOUR;
                    end
                    else
                    begin
                        minute_next = (minute_reg >= MIN_MAX) ? '0 : minute_reg + 1'b1;
                        action      = ACT_INC_MIN;
                    end
                end
                else if (last_pattern_reg == BTN_NONE && item.buttons == BTN_MENU)
                begin
                    hold_start_next   = item.now_ticks;
                    last_pattern_next = item.buttons;
                    position_next     = ~position_reg;
                    action            = ACT_TOGGLE;
                end
                else if (last_pattern_reg == BTN_MENU && item.buttons == BTN_MENU &&
                         elapsed_above(item.now_ticks, hold_start_reg,
                                       cfg.long_press_limit))
                begin
                    last_pattern_next = BTN_NONE;
                    hold_start_next   = '0;
                    action            = ACT_DONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pattern_reg <= BTN_NONE;
            hold_start_reg   <= '0;
            click_start_reg  <= '0;
            click_armed_reg  <= 1'b0;
            position_reg     <= POS_HOURS;
            hour_reg         <= '0;
            minute_reg       <= '0;
        end
        else if (advance)
        begin
            last_pattern_reg <= last_pattern_next;
            hold_start_reg   <= hold_start_next;
            click_start_reg  <= click_start_next;
            click_armed_reg  <= click_armed_next;
            position_reg     <= position_next;
            hour_reg         <= hour_next;
            minute_reg       <= minute_next;
        end
    end

    assign result.action         = action;
    assign result.hours          = hour_next;
    assign result.minutes        = minute_next;
    assign result.field_selected = position_next;

endmodule

`default_nettype wire

// ===== rtl/clock_time_set_controller.sv =====
// Top level of the clock time-set controller: input register, step logic,
// result register and configuration port. Depends on ctsc_pkg, ctsc_cfg,
// ctsc_step.
//
//  channel | signals                                              | dir
//  --------+------------------------------------------------------+----
//  in      | in_valid/in_ready, command, buttons, now_ticks,      | in
//          | load_hours, load_minutes                             |
//  out     | out_valid/out_ready, action, hours, minutes,         | out
//          | field_selected                                       |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data             | in
//
// Each item passes from its input beat to its result beat through the
// input register, then the step logic updates the state and loads the
// result register. One item per cycle is sustained while out_ready is
// high; the loop from the state registers through the step logic back
// to themselves sets that. Reset clears the state to hours 0, minutes 0,
// hours selected, and the registers to click_delay 200 and long_press_limit
// 2000. When out_ready is low the result register holds, then the input
// register holds and in_ready drops. cfg_ready is always high.
`default_nettype none

module clock_time_set_controller
    import ctsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              command,
    input  wire logic [2:0]        buttons,
    input  wire logic [31:0]       now_ticks,
    input  wire logic [HOUR_W-1:0] load_hours,
    input  wire logic [MIN_W-1:0]  load_minutes,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             action,
    output logic [HOUR_W-1:0]      hours,
    output logic [MIN_W-1:0]       minutes,
    output logic                   field_selected,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire cfg_word_t         cfg_data
);

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result;
    cfg_t    cfg;
    logic    advance;
    logic    in_beat;

    // Move an item from the input register into the result register when
    // the result register is empty or being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_beat  = in_valid && in_ready;

    assign cfg_ready = 1'b1;

    ctsc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ctsc_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Control flags of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture on an input beat, load the result on advance.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            item_reg.command      <= command;
            item_reg.buttons      <= buttons;
            item_reg.now_ticks    <= TICK_WIDTH'(now_ticks);
            item_reg.load_hours   <= load_hours;
            item_reg.load_minutes <= load_minutes;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign action         = result_reg.action;
    assign hours          = result_reg.hours;
    assign minutes        = result_reg.minutes;
    assign field_selected = result_reg.field_selected;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for clock_time_set_controller: a directed table, then
// random button sequences under several register settings, with random idling.
// Depends on ctsc_pkg and the RTL top level only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ctsc_pkg::*;

    localparam logic [2:0] PRESS_DOWN = 3'(1 << BTN_DOWN_BIT);
    localparam logic [2:0] PRESS_UP   = 3'(1 << BTN_UP_BIT);
    localparam logic [2:0] PRESS_ALL  = PRESS_DOWN | PRESS_UP | BTN_MENU;
    localparam cfg_word_t  WORD_MAX   = '1;
    localparam int         NUM_PHASES  = 7;
    localparam int         PHASE_ITEMS = 175;

    // One row of the directed table: the input beat and, where it is obvious,
    // the result typed in by hand.
    typedef struct {
        item_t   beat;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              command = CMD_LOAD;
    logic [2:0]        buttons = BTN_NONE;
    logic [31:0]       now_ticks = '0;
    logic [HOUR_W-1:0] load_hours = '0;
    logic [MIN_W-1:0]  load_minutes = '0;

    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        action;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic              field_selected;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = CFG_CLICK_DELAY;
    cfg_word_t         cfg_data = '0;

    // Shadow copy of the controller: registers and press/timer state.
    cfg_word_t         cfg_click_delay = 32'd200;
    cfg_word_t         cfg_long_press  = 32'd2000;
    logic [2:0]        prev_pattern    = BTN_NONE;
    tick_t             menu_hold_start = '0;
    tick_t             click_t0        = '0;
    logic              click_pending   = 1'b0;
    logic              sel_field       = POS_HOURS;
    logic [HOUR_W-1:0] hour_val        = '0;
    logic [MIN_W-1:0]  min_val         = '0;

    // Results still owed by the block, oldest first.
    result_t time_expect_q[$];

    bit gaps_on = 1'b1;
    int fail_count = 0;
    int items_sent = 0;
    int beats_checked = 0;
    int settings_used = 1;
    int action_tally[8];

    clock_time_set_controller u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .buttons       (buttons),
        .now_ticks     (now_ticks),
        .load_hours    (load_hours),
        .load_minutes  (load_minutes),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .action        (action),
        .hours         (hours),
        .minutes       (minutes),
        .field_selected(field_selected),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advance the shadow state by one accepted beat and return the result it owes.
    function automatic result_t predict_time_set(item_t it);
        result_t r;
        action_t act;
        tick_t   since;
        tick_t   held;
        act = ACT_NONE;
        if (it.command == CMD_LOAD)
        begin
            // Out-of-range loads clamp to the top of each field.
            hour_val = (it.load_hours > HOUR_MAX) ? HOUR_MAX : it.load_hours;
            min_val  = (it.load_minutes > MIN_MAX) ? MIN_MAX : it.load_minutes;
        end
        else if (it.buttons == BTN_NONE)
        begin
            // Release drops the press history but leaves the click timer as it is.
            prev_pattern    = BTN_NONE;
            menu_hold_start = '0;
        end
        else
        begin
            if (!click_pending)
            begin
                click_t0      = it.now_ticks;
                click_pending = 1'b1;
            end
            since = it.now_ticks - click_t0;
            if (since >= cfg_click_delay)
            begin
                click_pending = 1'b0;
                held = it.now_ticks - menu_hold_start;
                // Priority: down, then up, then menu alone.
                if (it.buttons[BTN_DOWN_BIT])
                begin
                    if (sel_field == POS_HOURS)
                    begin
                        hour_val = (hour_val == '0) ? HOUR_MAX : hour_val - 5'd1;
                        act = ACT_DEC_HOUR;
                    end
                    else
                    begin
                        min_val = (min_val == '0) ? MIN_MAX : min_val - 6'd1;
                        act = ACT_DEC_MIN;
                    end
                end
                else if (it.buttons[BTN_UP_BIT])
                begin
                    if (sel_field == POS_HOURS)
                    begin
                        hour_val = (hour_val >= HOUR_MAX) ? '0 : hour_val + 5'd1;
                        act = ACT_INC_HOUR;
                    end
                    else
                    begin
                        min_val = (min_val >= MIN_MAX) ? '0 : min_val + 6'd1;
                        act = ACT_INC_MIN;
                    end
                end
                else if (prev_pattern == BTN_NONE && it.buttons == BTN_MENU)
                begin
                    menu_hold_start = it.now_ticks;
                    prev_pattern    = it.buttons;
                    sel_field       = ~sel_field;
                    act = ACT_TOGGLE;
                end
                else if (prev_pattern == BTN_MENU && it.buttons == BTN_MENU &&
                         held > cfg_long_press)
                begin
                    prev_pattern    = BTN_NONE;
                    menu_hold_start = '0;
                    act = ACT_DONE;
                end
            end
        end
        r.action         = act;
        r.hours          = hour_val;
        r.minutes        = min_val;
        r.field_selected = sel_field;
        return r;
    endfunction

    function automatic stim_row_t stim_row(logic cmd, logic [2:0] btn, tick_t now,
                                           logic [HOUR_W-1:0] lh, logic [MIN_W-1:0] lm,
                                           bit typed, action_t act,
                                           logic [HOUR_W-1:0] h, logic [MIN_W-1:0] m,
                                           logic sel);
        stim_row_t row;
        row.beat.command      = cmd;
        row.beat.buttons      = btn;
        row.beat.now_ticks    = now;
        row.beat.load_hours   = lh;
        row.beat.load_minutes = lm;
        row.typed                = typed;
        row.want.action          = act;
        row.want.hours           = h;
        row.want.minutes         = m;
        row.want.field_selected  = sel;
        return row;
    endfunction

    // Tick advance between samples: mostly steps that land right at or next to
    // the click delay and the long-press limit, so both boundaries get hit.
    function automatic tick_t tick_step();
        tick_t step;
        case ($urandom_range(0, 9))
            0: step = '0;
            1: step = tick_t'($urandom_range(1, 16));
            2: step = cfg_click_delay - 32'd1;
            3, 4: step = cfg_click_delay;
            5: step = cfg_click_delay + 32'd1;
            6: step = cfg_long_press;
            7: step = cfg_long_press + 32'd1;
            8: step = cfg_long_press + 32'd2;
            default: step = tick_t'($urandom);
        endcase
        return step;
    endfunction

    // Present one beat, hold it until accepted, then log what it owes.
    task automatic send_item(item_t it, bit typed, result_t want);
        result_t predicted;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= it.command;
        buttons      <= it.buttons;
        now_ticks    <= it.now_ticks;
        load_hours   <= it.load_hours;
        load_minutes <= it.load_minutes;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = predict_time_set(it);
        time_expect_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Drop valid and wait until every owed result has come back, then let the
    // input and result registers settle so the block is truly quiet.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (time_expect_q.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write both registers in back-to-back beats, valid held high across them.
    task automatic write_registers(cfg_word_t delay, cfg_word_t limit);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CLICK_DELAY;
        cfg_data  <= delay;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_click_delay = delay;
        cfg_index <= CFG_LONG_PRESS;
        cfg_data  <= limit;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_long_press = limit;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random traffic: mostly press-and-hold sequences closed by a release,
    // with some loads and some fully random beats mixed in.
    task automatic run_random_phase(int n_items);
        int         sent;
        int         pick;
        int         len;
        tick_t      tick_cursor;
        logic [2:0] pattern;
        item_t      it;
        result_t    none_typed;
        sent        = 0;
        none_typed  = '0;
        tick_cursor = tick_t'($urandom);
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            it = '0;
            it.now_ticks    = tick_t'($urandom);
            it.load_hours   = HOUR_W'($urandom);
            it.load_minutes = MIN_W'($urandom);
            if (pick < 8)
            begin
                it.command = CMD_LOAD;
                it.buttons = 3'($urandom);
                if ($urandom_range(0, 3) != 0)
                begin
                    it.load_hours   = HOUR_W'($urandom_range(0, 23));
                    it.load_minutes = MIN_W'($urandom_range(0, 59));
                end
                send_item(it, 1'b0, none_typed);
                sent++;
            end
            else if (pick < 18)
            begin
                it.command = 1'($urandom);
                it.buttons = 3'($urandom);
                send_item(it, 1'b0, none_typed);
                sent++;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1: pattern = BTN_MENU;
                    2: pattern = PRESS_DOWN;
                    3: pattern = PRESS_UP;
                    default: pattern = 3'($urandom_range(1, 7));
                endcase
                len = $urandom_range(1, 8);
                it.command = CMD_SAMPLE;
                repeat (len + 1)
                begin
                    tick_cursor += tick_step();
                    it.now_ticks = tick_cursor;
                    it.buttons   = (sent < n_items) ? pattern : BTN_NONE;
                    send_item(it, 1'b0, none_typed);
                    sent++;
                end
                // Close the sequence with a release.
                tick_cursor += tick_step();
                it.now_ticks = tick_cursor;
                it.buttons   = BTN_NONE;
                send_item(it, 1'b0, none_typed);
                sent++;
            end
        end
    endtask

    // Receiver: ready in stretches, with stall bursts while idling is on.
    initial
    begin
        forever
        begin
            @(posedge clk);
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 40)) @(posedge clk);
            if (gaps_on && $urandom_range(0, 2) == 0)
            begin
                @(posedge clk);
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 17)) @(posedge clk);
            end
        end
    end

    // Compare every result beat with the oldest owed result.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (time_expect_q.size() == 0)
            begin
                $error("result beat with nothing owed: action %0d hours %0d minutes %0d",
                       action, hours, minutes);
                fail_count++;
            end
            else
            begin
                want = time_expect_q.pop_front();
                beats_checked++;
                action_tally[action]++;
                if (action !== want.action)
                begin
                    $error("action: expected %0d, got %0d", want.action, action);
                    fail_count++;
                end
                if (hours !== want.hours)
                begin
                    $error("hours: expected %0d, got %0d", want.hours, hours);
                    fail_count++;
                end
                if (minutes !== want.minutes)
                begin
                    $error("minutes: expected %0d, got %0d", want.minutes, minutes);
                    fail_count++;
                end
                if (field_selected !== want.field_selected)
                begin
                    $error("field_selected: expected %0d, got %0d",
                           want.field_selected, field_selected);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t rows[$];
        cfg_word_t phase_delay[NUM_PHASES];
        cfg_word_t phase_limit[NUM_PHASES];

        // Register settings per random phase; the first keeps the reset values.
        phase_delay[0] = 32'd200;
        phase_limit[0] = 32'd2000;
        phase_delay[1] = '0;
        phase_limit[1] = '0;
        phase_delay[2] = WORD_MAX;
        phase_limit[2] = WORD_MAX;
        phase_delay[3] = cfg_word_t'($urandom_range(1, 50));
        phase_limit[3] = cfg_word_t'($urandom_range(1, 300));
        phase_delay[4] = WORD_MAX;
        phase_limit[4] = '0;
        phase_delay[5] = '0;
        phase_limit[5] = WORD_MAX;
        phase_delay[6] = cfg_word_t'($urandom_range(1, 20));
        phase_limit[6] = cfg_word_t'($urandom_range(1, 100));

        // Directed table, run with the reset register values (200 / 2000).
        // Release right after reset, then a load that clamps both fields.
        rows.push_back(stim_row(CMD_SAMPLE, BTN_NONE, 32'd0, 5'd0, 6'd0,
                                1, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        rows.push_back(stim_row(CMD_LOAD, BTN_NONE, 32'd0, 5'd31, 6'd63,
                                1, ACT_NONE, 5'd23, 6'd59, POS_HOURS));
        // Up held: arms, one tick short of the delay, then exactly on it (hour wraps).
        rows.push_back(stim_row(CMD_SAMPLE, PRESS_UP, 32'd100, 5'd0, 6'd0,
                                0, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        rows.push_back(stim_row(CMD_SAMPLE, PRESS_UP, 32'd299, 5'd0, 6'd0,
                                0, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        rows.push_back(stim_row(CMD_SAMPLE, PRESS_UP, 32'd300, 5'd0, 6'd0,
                                1, ACT_INC_HOUR, 5'd0, 6'd59, POS_HOURS));
        // Down from hour zero wraps to 23.
        rows.push_back(stim_row(CMD_SAMPLE, PRESS_DOWN, 32'd300, 5'd0, 6'd0,
                                0, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        rows.push_back(stim_row(CMD_SAMPLE, PRESS_DOWN, 32'd500, 5'd0, 6'd0,
                                1, ACT_DEC_HOUR, 5'd23, 6'd59, POS_HOURS));
        rows.push_back(stim_row(CMD_SAMPLE, BTN_NONE, 32'd600, 5'd0, 6'd0,
                                0, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        // Menu from idle toggles, held exactly to the limit does nothing,
        // held past it finishes once the click delay has elapsed again.
        rows.push_back(stim_row(CMD_SAMPLE, BTN_MENU, 32'd1000, 5'd0, 6'd0,
                                0, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        rows.push_back(stim_row(CMD_SAMPLE, BTN_MENU, 32'd1200, 5'd0, 6'd0,
                                1, ACT_TOGGLE, 5'd23, 6'd59, POS_MINUTES));
        rows.push_back(stim_row(CMD_SAMPLE, BTN_MENU, 32'd1400, 5'd0, 6'd0,
                                0, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        rows.push_back(stim_row(CMD_SAMPLE, BTN_MENU, 32'd3200, 5'd0, 6'd0,
                                1, ACT_NONE, 5'd23, 6'd59, POS_MINUTES));
        rows.push_back(stim_row(CMD_SAMPLE, BTN_MENU, 32'd3201, 5'd0, 6'd0,
                                0, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        rows.push_back(stim_row(CMD_SAMPLE, BTN_MENU, 32'd3401, 5'd0, 6'd0,
                                1, ACT_DONE, 5'd23, 6'd59, POS_MINUTES));
        rows.push_back(stim_row(CMD_SAMPLE, BTN_NONE, 32'd3500, 5'd0, 6'd0,
                                0, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        // Tick counter wraps between arm and action; minutes wrap both ways.
        rows.push_back(stim_row(CMD_SAMPLE, PRESS_UP, 32'hFFFF_FF00, 5'd0, 6'd0,
                                0, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        rows.push_back(stim_row(CMD_SAMPLE, PRESS_UP, 32'h0000_0010, 5'd0, 6'd0,
                                1, ACT_INC_MIN, 5'd23, 6'd0, POS_MINUTES));
        rows.push_back(stim_row(CMD_SAMPLE, PRESS_DOWN, 32'h0000_0020, 5'd0, 6'd0,
                                0, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        rows.push_back(stim_row(CMD_SAMPLE, PRESS_DOWN, 32'h0000_00E8, 5'd0, 6'd0,
                                1, ACT_DEC_MIN, 5'd23, 6'd59, POS_MINUTES));
        // All buttons: down wins.
        rows.push_back(stim_row(CMD_SAMPLE, PRESS_ALL, 32'h0000_0200, 5'd0, 6'd0,
                                0, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        rows.push_back(stim_row(CMD_SAMPLE, PRESS_ALL, 32'h0000_0300, 5'd0, 6'd0,
                                1, ACT_DEC_MIN, 5'd23, 6'd58, POS_MINUTES));
        rows.push_back(stim_row(CMD_SAMPLE, BTN_NONE, 32'h0000_0400, 5'd0, 6'd0,
                                0, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        // Up with menu from idle: up wins, menu never toggles.
        rows.push_back(stim_row(CMD_SAMPLE, PRESS_UP | BTN_MENU, 32'h0000_1000, 5'd0, 6'd0,
                                0, ACT_NONE, 5'd0, 6'd0, POS_HOURS));
        rows.push_back(stim_row(CMD_SAMPLE, PRESS_UP | BTN_MENU, 32'h0000_1100, 5'd0, 6'd0,
                                1, ACT_INC_MIN, 5'd23, 6'd59, POS_MINUTES));
        // Load ignores buttons and ticks and keeps the selected field.
        rows.push_back(stim_row(CMD_LOAD, PRESS_ALL, 32'hFFFF_FFFF, 5'd0, 6'd0,
                                1, ACT_NONE, 5'd0, 6'd0, POS_MINUTES));

        // Hold reset low at the start, then release it on a rising edge.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].beat, rows[i].typed, rows[i].want);
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p != 0)
                write_registers(phase_delay[p], phase_limit[p]);
            // Last phase runs flat out on both sides.
            if (p == NUM_PHASES - 1)
                gaps_on = 1'b0;
            run_random_phase(PHASE_ITEMS);
            drain_results();
        end

        $display("Covered %0d input beats and %0d result beats over %0d register settings",
                 items_sent, beats_checked, settings_used);
        $display("Actions seen: inc/dec %0d, toggle %0d, done %0d, none %0d",
                 action_tally[ACT_INC_HOUR] + action_tally[ACT_DEC_HOUR] +
                 action_tally[ACT_INC_MIN] + action_tally[ACT_DEC_MIN],
                 action_tally[ACT_TOGGLE], action_tally[ACT_DONE], action_tally[ACT_NONE]);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ctsc_pkg.sv
rtl/ctsc_cfg.sv
rtl/ctsc_step.sv
rtl/clock_time_set_controller.sv
dv/testbench.sv
